### design/concentric_square_to_disk_map_defines.svh
// assertion macros for the concentric square to disk map
// used by the top level, needs i_clk and i_rst_n in scope
`ifndef CONCENTRIC_SQUARE_TO_DISK_MAP_DEFINES_SVH
`define CONCENTRIC_SQUARE_TO_DISK_MAP_DEFINES_SVH

// condition must hold in the same cycle
`define CSDM_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define CSDM_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/csdm_pkg.sv
// shared types, constants and helper functions of the disk map pipeline
// no dependencies
package csdm_pkg;

    localparam int XY_W = 34;
    localparam int Z_W  = 33;

    localparam logic [29:0] KINV_Q30    = 30'h26DD3B6A;
    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    localparam logic [1:0] WEDGE_RIGHT = 2'd0;
    localparam logic [1:0] WEDGE_TOP   = 2'd1;
    localparam logic [1:0] WEDGE_LEFT  = 2'd2;
    localparam logic [1:0] WEDGE_BOT   = 2'd3;

    typedef struct packed {
        logic                   vld;
        logic [1:0]             quad;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    function automatic logic [31:0] atan_phase(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] t;
        t = ($signed({v[XY_W-1], v}) + $signed((XY_W+1)'(16384))) >>> 15;
        if (t > $signed((XY_W+1)'(32767))) begin
            return 16'h7FFF;
        end else if (t < -$signed((XY_W+1)'(32768))) begin
            return 16'h8000;
        end
        return t[15:0];
    endfunction

endpackage

### design/concentric_square_to_disk_map.sv
// concentric square to disk map, fully pipelined, one item per cycle while not stalled
// stages in order: input register, 31 divider steps,
// angle stage, gain multiply, cordic stages, output register
// the whole pipe holds while the output item waits and the sink is not ready
// synchronous active-low reset clears every valid bit, payload is not reset
// depends on csdm_pkg, csdm_cordic_stage and the defines header
`include "concentric_square_to_disk_map_defines.svh"

module concentric_square_to_disk_map #(
    parameter int COORD_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // sample_u [15:0], sample_v [31:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // disk_x [15:0], disk_y [31:16]
);
    import csdm_pkg::*;

    localparam int CB        = COORD_BITS;
    localparam int NW        = CB + 31;
    localparam int DIV_STEPS = 31;
    localparam int NSTG      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    typedef struct packed {
        logic          vld;
        logic [CB+1:0] rem;
        logic [30:0]   low;
        logic [30:0]   q;
        logic [CB:0]   d;
        logic [1:0]    wedge;
        logic          sgn;
        logic          dz;
    } t_div;

    typedef struct packed {
        logic                  vld;
        logic [1:0]            quad;
        logic signed [Z_W-1:0] z;
        logic [30:0]           rq;
    } t_theta;

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // input stage
    logic [CB-1:0]        u;
    logic [CB-1:0]        v;
    logic signed [CB+1:0] a;
    logic signed [CB+1:0] b;
    logic signed [CB+2:0] s;
    logic signed [CB+1:0] num;
    logic signed [CB+1:0] den;
    logic [CB:0]          nmag;
    logic [CB:0]          dmag;
    logic [NW-1:0]        big_n;
    t_div                 n_dv0;

    always_comb begin
        u = CB'(i_s_tdata[15:0]);
        v = CB'(i_s_tdata[31:16]);
        a = $signed({1'b0, u, 1'b0}) - $signed({2'b01, {CB{1'b0}}});
        b = $signed({1'b0, v, 1'b0}) - $signed({2'b01, {CB{1'b0}}});
        s = $signed({a[CB+1], a}) + $signed({b[CB+1], b});
        n_dv0 = '0;
        if (!s[CB+2] && (s != '0)) begin
            n_dv0.wedge = (a > b) ? WEDGE_RIGHT : WEDGE_TOP;
        end else begin
            n_dv0.wedge = (a < b) ? WEDGE_LEFT : WEDGE_BOT;
        end
        if ((n_dv0.wedge == WEDGE_RIGHT) || (n_dv0.wedge == WEDGE_LEFT)) begin
            num = b;
            den = a;
        end else begin
            num = a;
            den = b;
        end
        nmag  = num[CB+1] ? (CB+1)'(-num) : (CB+1)'(num);
        dmag  = den[CB+1] ? (CB+1)'(-den) : (CB+1)'(den);
        big_n = NW'({nmag, 30'b0}) + NW'(dmag);
        n_dv0.vld = i_s_tvalid;
        n_dv0.rem = (CB+2)'(big_n[NW-1:31]);
        n_dv0.low = big_n[30:0];
        n_dv0.d   = dmag;
        n_dv0.sgn = num[CB+1] ^ den[CB+1];
        n_dv0.dz  = (den == '0);
    end

    t_div r_dv [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else if (w_en) begin
            r_dv[0].vld <= n_dv0.vld;
        end
        if (w_en) begin
            r_dv[0].rem   <= n_dv0.rem;
            r_dv[0].low   <= n_dv0.low;
            r_dv[0].q     <= n_dv0.q;
            r_dv[0].d     <= n_dv0.d;
            r_dv[0].wedge <= n_dv0.wedge;
            r_dv[0].sgn   <= n_dv0.sgn;
            r_dv[0].dz    <= n_dv0.dz;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int BIT = DIV_STEPS - 1 - k;
        logic [CB+2:0] t;
        logic [CB+2:0] dd;
        t_div          n_dv;

        always_comb begin
            t    = {r_dv[k].rem, r_dv[k].low[BIT]};
            dd   = {1'b0, r_dv[k].d, 1'b0};
            n_dv = r_dv[k];
            if (t >= dd) begin
                n_dv.rem    = (CB+2)'(t - dd);
                n_dv.q[BIT] = 1'b1;
            end else begin
                n_dv.rem = (CB+2)'(t);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1].vld <= 1'b0;
            end else if (w_en) begin
                r_dv[k+1].vld <= n_dv.vld;
            end
            if (w_en) begin
                r_dv[k+1].rem   <= n_dv.rem;
                r_dv[k+1].low   <= n_dv.low;
                r_dv[k+1].q     <= n_dv.q;
                r_dv[k+1].d     <= n_dv.d;
                r_dv[k+1].wedge <= n_dv.wedge;
                r_dv[k+1].sgn   <= n_dv.sgn;
                r_dv[k+1].dz    <= n_dv.dz;
            end
        end
    end

    // angle stage: wedge offset, quarter-turn split, radius scaling
    t_div          dv_end;
    logic [31:0]   q32;
    logic [31:0]   off;
    logic          flip;
    logic [31:0]   theta;
    logic [31:0]   ph_r;
    logic [1:0]    quad;
    logic [31:0]   resid;
    logic [CB+30:0] rwide;
    t_theta        n_th;
    t_theta        r_th;

    always_comb begin
        dv_end = r_dv[DIV_STEPS];
        q32    = {1'b0, dv_end.q};
        case (dv_end.wedge)
            WEDGE_RIGHT: begin off = 32'd0;              flip = 1'b0; end
            WEDGE_TOP:   begin off = EIGHTH_TURN << 1;   flip = 1'b1; end
            WEDGE_LEFT:  begin off = EIGHTH_TURN << 2;   flip = 1'b0; end
            default:     begin off = 32'hC000_0000;      flip = 1'b1; end
        endcase
        theta = (flip ^ dv_end.sgn) ? off - q32 : off + q32;
        if (dv_end.dz) begin
            theta = 32'd0;
        end
        ph_r  = theta + EIGHTH_TURN;
        quad  = ph_r[31:30];
        resid = theta - {quad, 30'b0};
        rwide = {dv_end.d, 30'b0} >> CB;
        n_th.vld  = dv_end.vld;
        n_th.quad = quad;
        n_th.z    = $signed({resid[31], resid});
        n_th.rq   = 31'(rwide);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th.vld <= 1'b0;
        end else if (w_en) begin
            r_th.vld <= n_th.vld;
        end
        if (w_en) begin
            r_th.quad <= n_th.quad;
            r_th.z    <= n_th.z;
            r_th.rq   <= n_th.rq;
        end
    end

    // gain compensation multiply
    logic [61:0] prod;
    t_cordic     n_mu;
    t_cordic     cstg [0:NSTG];

    always_comb begin
        prod      = 62'(r_th.rq) * 62'(KINV_Q30) + 62'(1 << 29);
        n_mu.vld  = r_th.vld;
        n_mu.quad = r_th.quad;
        n_mu.x    = $signed(XY_W'(prod[61:30]));
        n_mu.y    = '0;
        n_mu.z    = r_th.z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            cstg[0].vld <= 1'b0;
        end else if (w_en) begin
            cstg[0].vld <= n_mu.vld;
        end
        if (w_en) begin
            cstg[0].quad <= n_mu.quad;
            cstg[0].x    <= n_mu.x;
            cstg[0].y    <= n_mu.y;
            cstg[0].z    <= n_mu.z;
        end
    end

    for (genvar i = 0; i < NSTG; i++) begin : g_cordic
        csdm_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stg   (cstg[i]),
            .o_stg   (cstg[i+1])
        );
    end

    // quarter-turn rotation, rounding and saturation
    t_cordic                c_end;
    logic signed [XY_W-1:0] rx;
    logic signed [XY_W-1:0] ry;
    logic [15:0]            n_out_x;
    logic [15:0]            n_out_y;
    logic                   r_out_vld;
    logic [15:0]            r_out_x;
    logic [15:0]            r_out_y;

    always_comb begin
        c_end = cstg[NSTG];
        case (c_end.quad)
            2'd1:    begin rx = -c_end.y; ry = c_end.x;  end
            2'd2:    begin rx = -c_end.x; ry = -c_end.y; end
            2'd3:    begin rx = c_end.y;  ry = -c_end.x; end
            default: begin rx = c_end.x;  ry = c_end.y;  end
        endcase
        n_out_x = sat16(rx);
        n_out_y = sat16(ry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= c_end.vld;
        end
        if (w_en) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_y, r_out_x};

    `CSDM_AST_NOW(a_quot_bound, dv_end.vld && !dv_end.dz, dv_end.q <= 31'h2000_0000, "quotient above an eighth turn")
    `CSDM_AST_NOW(a_rem_bound, dv_end.vld && !dv_end.dz, {1'b0, dv_end.rem} < {1'b0, dv_end.d, 1'b0}, "divider remainder not below divisor")
    `CSDM_AST_NOW(a_resid_range, r_th.vld, (r_th.z >= -$signed(Z_W'(32'h2000_0000))) && (r_th.z < $signed(Z_W'(32'h2000_0000))), "residual angle out of range")
    `CSDM_AST_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "output item changed while stalled")

endmodule

### design/csdm_cordic_stage.sv
// one registered micro-rotation of the rotation-mode cordic
// depends on csdm_pkg
module csdm_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  csdm_pkg::t_cordic i_stg,
    output csdm_pkg::t_cordic o_stg
);
    import csdm_pkg::*;

    t_cordic r_stg;
    t_cordic n_stg;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;

    always_comb begin
        dx  = i_stg.y >>> STAGE;
        dy  = i_stg.x >>> STAGE;
        ang = $signed({1'b0, atan_phase(5'(STAGE))});
        n_stg = i_stg;
        if (!i_stg.z[Z_W-1]) begin
            n_stg.x = i_stg.x - dx;
            n_stg.y = i_stg.y + dy;
            n_stg.z = i_stg.z - ang;
        end else begin
            n_stg.x = i_stg.x + dx;
            n_stg.y = i_stg.y - dy;
            n_stg.z = i_stg.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg.vld <= 1'b0;
        end else if (i_en) begin
            r_stg.vld <= i_stg.vld;
        end
        if (i_en) begin
            r_stg.quad <= n_stg.quad;
            r_stg.x    <= n_stg.x;
            r_stg.y    <= n_stg.y;
            r_stg.z    <= n_stg.z;
        end
    end

    assign o_stg = r_stg;

endmodule
